// ===== sv/priority_task_queue_core_macros.svh =====
// Assertion macros shared by the queue's checker.
`ifndef PRIORITY_TASK_QUEUE_CORE_MACROS_SVH
`define PRIORITY_TASK_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define PTQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define PTQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/ptq_pkg.sv =====
// Shared types, constants and codes of the priority task queue.
package ptq_pkg;

   localparam int LEVEL_DEPTH_DEF = 16;
   localparam int ID_BITS_DEF     = 16;
   localparam int NUM_LEVELS      = 4;
   localparam int LQ_W            = 2;

   localparam int TASK_W  = 16;
   localparam int LEVEL_W = 3;
   localparam int PEND_W  = 7;
   localparam int STAT_W  = 2;

   localparam logic [LEVEL_W-1:0] LEVEL_LOW      = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_CRITICAL = 3'd4;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STAT_W-1:0] ST_PUSHED  = 2'd0;
   localparam logic [STAT_W-1:0] ST_DROPPED = 2'd1;
   localparam logic [STAT_W-1:0] ST_POPPED  = 2'd2;
   localparam logic [STAT_W-1:0] ST_NONE    = 2'd3;

   typedef struct packed {
      logic               opcode;
      logic [TASK_W-1:0]  task_id_in;
      logic [LEVEL_W-1:0] level_in;
      logic [LEVEL_W-1:0] min_level;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]  status;
      logic [TASK_W-1:0]  task_id_out;
      logic [LEVEL_W-1:0] level_out;
      logic [PEND_W-1:0]  pending;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic commit;
      logic load;
   } cmd_type;

   typedef struct packed {
      logic out_busy;
   } sts_type;

endpackage

// ===== sv/ptq_ctrl.sv =====
// Controller state machine of the priority task queue.
module ptq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptq_pkg::sts_type sts,
   output ptq_pkg::cmd_type cmd
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_EXEC = 2'd1;
   localparam logic [1:0] S_LOAD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.commit  = 1'b0;
      cmd.load    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            // Hold the operation until the result register is free.
            if (!sts.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = S_LOAD;
            end
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/ptq_datapath.sv =====
// Datapath of the priority task queue: task store, pointers, counts, result register.
module ptq_datapath #(
   parameter int LEVEL_DEPTH = ptq_pkg::LEVEL_DEPTH_DEF,
   parameter int ID_BITS     = ptq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  ptq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptq_pkg::rsp_type rsp_payload,
   input  ptq_pkg::cmd_type cmd,
   output ptq_pkg::sts_type sts
);

   localparam int PTR_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   localparam int CNT_W = $clog2(LEVEL_DEPTH + 1);
   localparam int TOT_W = $clog2(ptq_pkg::NUM_LEVELS * LEVEL_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(LEVEL_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(LEVEL_DEPTH);

   logic [ID_BITS-1:0] level_store_ff [ptq_pkg::NUM_LEVELS][LEVEL_DEPTH];
   logic [ID_BITS-1:0] rd_data_ff;

   ptq_pkg::req_type req_ff;
   logic [PTR_W-1:0] rd_idx_ff [ptq_pkg::NUM_LEVELS];
   logic [PTR_W-1:0] rd_idx_in [ptq_pkg::NUM_LEVELS];
   logic [PTR_W-1:0] wr_idx_ff [ptq_pkg::NUM_LEVELS];
   logic [PTR_W-1:0] wr_idx_in [ptq_pkg::NUM_LEVELS];
   logic [CNT_W-1:0] cnt_ff    [ptq_pkg::NUM_LEVELS];
   logic [CNT_W-1:0] cnt_in    [ptq_pkg::NUM_LEVELS];
   logic [TOT_W-1:0] total_ff;
   logic [TOT_W-1:0] total_in;
   logic [ptq_pkg::STAT_W-1:0]  res_status_ff;
   logic [ptq_pkg::STAT_W-1:0]  res_status_in;
   logic [ptq_pkg::LEVEL_W-1:0] res_level_ff;
   logic [ptq_pkg::LEVEL_W-1:0] res_level_in;
   ptq_pkg::rsp_type out_ff;
   ptq_pkg::rsp_type out_in;
   logic out_valid_ff;
   logic out_valid_in;

   logic [ptq_pkg::LQ_W-1:0]    push_q;
   logic [ptq_pkg::LQ_W-1:0]    top_q;
   logic                        any_pending;
   logic [ptq_pkg::LEVEL_W-1:0] top_level;
   logic                        push_ok;
   logic                        pop_ok;
   logic                        do_write;

   function automatic logic [PTR_W-1:0] next_slot(input logic [PTR_W-1:0] slot);
      next_slot = (slot == LAST_SLOT) ? '0 : slot + 1'b1;
   endfunction

   // Saturate the push level into the four queues.
   always_comb begin
      if (req_ff.level_in <= ptq_pkg::LEVEL_LOW) begin
         push_q = '0;
      end else if (req_ff.level_in >= ptq_pkg::LEVEL_CRITICAL) begin
         push_q = ptq_pkg::LQ_W'(ptq_pkg::NUM_LEVELS - 1);
      end else begin
         push_q = ptq_pkg::LQ_W'(req_ff.level_in - ptq_pkg::LEVEL_LOW);
      end
   end

   // Highest non-empty level.
   always_comb begin
      any_pending = 1'b1;
      if (cnt_ff[3] != '0) begin
         top_q = 2'd3;
      end else if (cnt_ff[2] != '0) begin
         top_q = 2'd2;
      end else if (cnt_ff[1] != '0) begin
         top_q = 2'd1;
      end else begin
         top_q       = 2'd0;
         any_pending = (cnt_ff[0] != '0);
      end
   end

   assign top_level = {1'b0, top_q} + ptq_pkg::LEVEL_LOW;
   assign push_ok   = (cnt_ff[push_q] < FULL_CNT);
   assign pop_ok    = any_pending && (top_level >= req_ff.min_level);
   assign do_write  = cmd.commit && (req_ff.opcode == ptq_pkg::OP_PUSH) && push_ok;

   always_comb begin
      rd_idx_in     = rd_idx_ff;
      wr_idx_in     = wr_idx_ff;
      cnt_in        = cnt_ff;
      total_in      = total_ff;
      res_status_in = res_status_ff;
      res_level_in  = res_level_ff;
      if (cmd.commit) begin
         res_level_in = '0;
         if (req_ff.opcode == ptq_pkg::OP_PUSH) begin
            if (push_ok) begin
               wr_idx_in[push_q] = next_slot(wr_idx_ff[push_q]);
               cnt_in[push_q]    = cnt_ff[push_q] + 1'b1;
               total_in          = total_ff + 1'b1;
               res_status_in     = ptq_pkg::ST_PUSHED;
            end else begin
               res_status_in = ptq_pkg::ST_DROPPED;
            end
         end else begin
            if (pop_ok) begin
               rd_idx_in[top_q] = next_slot(rd_idx_ff[top_q]);
               cnt_in[top_q]    = cnt_ff[top_q] - 1'b1;
               total_in         = total_ff - 1'b1;
               res_status_in    = ptq_pkg::ST_POPPED;
               res_level_in     = top_level;
            end else begin
               res_status_in = ptq_pkg::ST_NONE;
            end
         end
      end
   end

   always_comb begin
      out_in       = out_ff;
      out_valid_in = out_valid_ff;
      if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
      if (cmd.load) begin
         out_valid_in       = 1'b1;
         out_in.status      = res_status_ff;
         out_in.level_out   = res_level_ff;
         out_in.pending     = ptq_pkg::PEND_W'(32'(total_ff));
         out_in.task_id_out = (res_status_ff == ptq_pkg::ST_POPPED) ?
                              ptq_pkg::TASK_W'(32'(rd_data_ff)) : '0;
      end
   end

   // Task store: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         level_store_ff[push_q][wr_idx_ff[push_q]] <= ID_BITS'(32'(req_ff.task_id_in));
      end
      rd_data_ff <= level_store_ff[top_q][rd_idx_ff[top_q]];
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      res_status_ff <= res_status_in;
      res_level_ff  <= res_level_in;
      out_ff        <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_idx_ff    <= '{default: '0};
         wr_idx_ff    <= '{default: '0};
         cnt_ff       <= '{default: '0};
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         cnt_ff       <= cnt_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_payload  = out_ff;
   assign sts.out_busy = out_valid_ff;

endmodule

// ===== sv/priority_task_queue_core.sv =====
// Top level of the four-level strict priority task queue.
//
// The req channel carries one operation per beat: a push stores a task id at
// its level (levels below one or above four are saturated), and a pop takes
// the oldest task of the highest non-empty level if that level is at least
// the pop's minimum. The rsp channel returns exactly one beat per request with
// a status code, the popped task and level, and the total count held.
// An operation runs through three steps: capture, execute and result load.
// The request is captured, executed into the result registers once the output
// register is free, and loaded into it; a new request is taken only when idle.
// The store's registered read port sets a pop's load step, which pushes share.
// When the receiver stalls, the result stays in the output register and one
// more request may still be taken; that request then waits in the execute
// step until the output register empties.
// Reset clears all pointers, counts and the output valid; the task store is
// not cleared, since only slots holding a pushed task are ever returned.
module priority_task_queue_core #(
   parameter int LEVEL_DEPTH = ptq_pkg::LEVEL_DEPTH_DEF,
   parameter int ID_BITS     = ptq_pkg::ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ptq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ptq_pkg::rsp_type rsp_payload
);

   // Commands from the controller and status back from the datapath.
   ptq_pkg::cmd_type cmd;
   ptq_pkg::sts_type sts;

   ptq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   ptq_datapath #(
      .LEVEL_DEPTH (LEVEL_DEPTH),
      .ID_BITS     (ID_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

// ===== sv/ptq_checker.sv =====
// Port-level checker of the priority task queue and its bind statement.
`include "priority_task_queue_core_macros.svh"

module ptq_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ptq_pkg::rsp_type rsp_payload
);

   `PTQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload), "stalled result beat changed")
   `PTQ_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && !req_stall, req_stall, "request taken while an operation is in flight")
   `PTQ_ASSERT_NOW(a_popped_level, clock, reset, rsp_valid && (rsp_payload.status == ptq_pkg::ST_POPPED), (rsp_payload.level_out != 3'd0) && (rsp_payload.level_out <= ptq_pkg::LEVEL_CRITICAL), "popped level out of range")
   `PTQ_ASSERT_NOW(a_no_pop_zero, clock, reset, rsp_valid && (rsp_payload.status != ptq_pkg::ST_POPPED), (rsp_payload.task_id_out == '0) && (rsp_payload.level_out == '0), "task fields not zero without a pop")

endmodule

bind priority_task_queue_core ptq_checker u_ptq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

// ===== tb/sv/tb_priority_task_queue_core.sv =====
// Self-checking testbench for the four-level strict priority task queue core.
module tb_priority_task_queue_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ptq_pkg::*;

   localparam int HALF_PERIOD   = 10;
   localparam int RESET_CYCLES  = 12;
   localparam int RANDOM_OPS    = 1750;
   localparam int IDLE_PCT      = 13;
   localparam int SHOWN_FAULTS  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_LIMIT   = 5000;

   // Shadow copy of the queue. Every accepted operation is applied to it in
   // acceptance order, and the outcome it implies is queued until the
   // matching result beat shows up on the rsp channel.
   class task_queue_ledger;
      logic [TASK_W-1:0] slot_id [NUM_LEVELS][LEVEL_DEPTH_DEF];
      int                head [NUM_LEVELS];
      int                tail [NUM_LEVELS];
      int                held [NUM_LEVELS];
      rsp_type           outcomes_due [$];
      int unsigned       faults;
      int unsigned       beats;

      function new();
         faults = 0;
         beats  = 0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            head[i] = 0;
            tail[i] = 0;
            held[i] = 0;
         end
      endfunction

      function int due();
         return outcomes_due.size();
      endfunction

      function void fault(string why);
         faults++;
         if (faults <= SHOWN_FAULTS) begin
            $display("ERROR at %0t: %s", $realtime, why);
         end
      endfunction

      // Applies one accepted operation to the shadow queue and records the
      // result beat it must produce.
      function void note_op(req_type op);
         rsp_type            want;
         logic [LEVEL_W-1:0] lv;
         int                 q;
         int                 top;
         int                 total;
         want = '0;
         if (op.opcode == OP_PUSH) begin
            // Out-of-range levels saturate into the low..critical span.
            lv = op.level_in;
            if (lv < LEVEL_LOW) lv = LEVEL_LOW;
            if (lv > LEVEL_CRITICAL) lv = LEVEL_CRITICAL;
            q = int'(lv - LEVEL_LOW);
            if (held[q] >= LEVEL_DEPTH_DEF) begin
               want.status = ST_DROPPED;
            end else begin
               slot_id[q][tail[q]] = op.task_id_in;
               tail[q] = (tail[q] + 1) % LEVEL_DEPTH_DEF;
               held[q]++;
               want.status = ST_PUSHED;
            end
         end else begin
            // Only the highest non-empty level is considered; when its head
            // is below the minimum, lower levels are not searched.
            want.status = ST_NONE;
            top = -1;
            for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
               if (top < 0 && held[i] != 0) top = i;
            end
            if (top >= 0 && top + int'(LEVEL_LOW) >= int'(op.min_level)) begin
               want.status      = ST_POPPED;
               want.task_id_out = slot_id[top][head[top]];
               want.level_out   = LEVEL_W'(top) + LEVEL_LOW;
               head[top] = (head[top] + 1) % LEVEL_DEPTH_DEF;
               held[top]--;
            end
         end
         total = 0;
         for (int i = 0; i < NUM_LEVELS; i++) total += held[i];
         want.pending = PEND_W'(total);
         outcomes_due.insert(outcomes_due.size(), want);
      endfunction

      // Compares one accepted result beat with the oldest outcome waiting.
      function void check_outcome(rsp_type got);
         rsp_type want;
         beats++;
         if (outcomes_due.size() == 0) begin
            fault($sformatf({"result beat %0d with no operation waiting: ",
                             "status=%0d id=%h level=%0d pending=%0d"},
                            beats, got.status, got.task_id_out, got.level_out,
                            got.pending));
            return;
         end
         want = outcomes_due.pop_front();
         if (got.status !== want.status || got.task_id_out !== want.task_id_out ||
             got.level_out !== want.level_out || got.pending !== want.pending) begin
            fault($sformatf({"result beat %0d: expected status=%0d id=%h level=%0d ",
                             "pending=%0d, got status=%0d id=%h level=%0d pending=%0d"},
                            beats, want.status, want.task_id_out, want.level_out,
                            want.pending, got.status, got.task_id_out, got.level_out,
                            got.pending));
         end
      endfunction
   endclass

   logic    clock       = 1'b0;
   logic    reset       = 1'b1;
   logic    req_valid   = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall   = 1'b0;
   rsp_type rsp_payload;

   task_queue_ledger ledger = new();

   // Handshake outcomes sampled at the falling edge. All inputs are driven
   // at the rising edge, so by mid-cycle everything has settled and these
   // flags tell which beats the next rising edge will take.
   logic    req_took = 1'b0;
   logic    rsp_took = 1'b0;
   req_type req_seen;
   rsp_type rsp_seen;

   int unsigned rsp_cycle = 0;

   priority_task_queue_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(negedge clock) begin
      req_took = !reset && req_valid && !req_stall;
      rsp_took = !reset && rsp_valid && !rsp_stall;
      req_seen = req_payload;
      rsp_seen = rsp_payload;
   end

   // The result is checked before the operation taken at the same edge is
   // noted: a result can never belong to a request accepted at its own edge.
   always @(posedge clock) begin
      if (rsp_took) ledger.check_outcome(rsp_seen);
      if (req_took) ledger.note_op(req_seen);
   end

   // Receiver back-pressure: random stalls, except for a long window in which the
   // result channel drains at full speed.
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (reset || (rsp_cycle >= 1500 && rsp_cycle < 3000)) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < IDLE_PCT);
      end
   end

   // Called at a rising edge. Optionally idles the channel with junk on the
   // payload, then presents the beat and holds it until it is taken. Returns at
   // the edge that accepted it.
   task automatic send_op(req_type op, bit quiet);
      if (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid   <= 1'b0;
         req_payload <= req_type'($urandom);
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= op;
      @(posedge clock);
      while (!req_took) @(posedge clock);
   endtask

   task automatic push_op(logic [TASK_W-1:0] id, logic [LEVEL_W-1:0] lvl);
      req_type op;
      op            = req_type'($urandom);
      op.opcode     = OP_PUSH;
      op.task_id_in = id;
      op.level_in   = lvl;
      send_op(op, 1'b0);
   endtask

   task automatic pop_op(logic [LEVEL_W-1:0] minl);
      req_type op;
      op           = req_type'($urandom);
      op.opcode    = OP_POP;
      op.min_level = minl;
      send_op(op, 1'b0);
   endtask

   // Holds the request channel idle until every outstanding result is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (ledger.due() != 0);
      @(posedge clock);
   endtask

   initial begin
      req_type     op;
      int unsigned sent;
      int unsigned blk;
      int unsigned push_pct;
      int unsigned favored;
      int unsigned pick;
      int          waited;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Pops on an empty queue, with a zero minimum as well.
      pop_op(3'd1);
      pop_op(3'd0);
      // Pushes at every level, including saturated levels zero, five and
      // seven, and the all-zero and all-one task ids.
      push_op(16'h0000, 3'd0);
      push_op(16'hFFFF, 3'd7);
      push_op(16'hA5A5, 3'd5);
      push_op(16'h5A5A, 3'd4);
      push_op(16'h0F0F, 3'd3);
      push_op(16'hF0F0, 3'd2);
      push_op(16'h8001, 3'd1);
      // A minimum above critical matches nothing.
      pop_op(3'd5);
      pop_op(3'd7);
      // Critical level drains oldest first, then the head of level three is
      // below a minimum of four, so nothing is eligible.
      pop_op(3'd4);
      pop_op(3'd0);
      pop_op(3'd1);
      pop_op(3'd4);
      pop_op(3'd3);
      pop_op(3'd2);
      pop_op(3'd2);
      pop_op(3'd1);
      pop_op(3'd1);
      pop_op(3'd1);
      drain_results();

      // Random part in blocks. Each block leans toward pushes or pops and
      // favors one level, so levels fill up to the point of dropping and
      // the whole queue empties again now and then.
      sent = 0;
      blk  = 0;
      while (sent < RANDOM_OPS) begin
         case ($urandom_range(3))
            0:       push_pct = 15;
            1:       push_pct = 50;
            2:       push_pct = 85;
            default: push_pct = 97;
         endcase
         favored = $urandom_range(1, 4);
         for (int k = 0; k < 60 && sent < RANDOM_OPS; k++) begin
            op.opcode     = ($urandom_range(99) < push_pct) ? OP_PUSH : OP_POP;
            op.task_id_in = TASK_W'($urandom);
            pick = $urandom_range(99);
            if (pick < 10) op.level_in = LEVEL_W'($urandom_range(7));
            else if (pick < 60) op.level_in = LEVEL_W'(favored);
            else op.level_in = LEVEL_W'($urandom_range(1, 4));
            pick = $urandom_range(99);
            if (pick < 10) op.min_level = LEVEL_W'($urandom_range(7));
            else if (pick < 55) op.min_level = LEVEL_LOW;
            else op.min_level = LEVEL_W'($urandom_range(1, 4));
            // A long run of back-to-back beats with no sender idling.
            send_op(op, sent >= 700 && sent < 1000);
            sent++;
         end
         blk++;
         if (blk % 7 == 3) drain_results();
      end

      // Wind down: wait for all outstanding results, then idle for the settle
      // time so that any stray extra beat is caught.
      req_valid <= 1'b0;
      waited = 0;
      while (ledger.due() != 0 && waited < DRAIN_LIMIT) begin
         @(negedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.due() != 0) begin
         $display("ERROR: %0d result beats never arrived", ledger.due());
      end
      if (ledger.faults == 0 && ledger.due() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Watchdog far beyond the slowest legal run.
   initial begin
      #4_000_000;
      $display("ERROR: watchdog expired with %0d results outstanding", ledger.due());
      $display("Regression FAIL");
      $finish;
   end

endmodule
